// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is high.
`define SORM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define SORM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sorm_pkg.sv
// ----------------------------------------------------------------------------
// sorm_pkg
// Widths, limits and register indexes of the short ORF masker.
// ----------------------------------------------------------------------------
`default_nettype none

package sorm_pkg;

  localparam int LETTER_W    = 7;
  localparam int MAX_MIN_LEN = 32;
  localparam int ADDR_W      = $clog2(MAX_MIN_LEN);
  localparam int CNT_W       = $clog2(MAX_MIN_LEN + 1);
  localparam int TOTAL_W     = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = {TOTAL_W{1'b1}};
  localparam logic [CNT_W-1:0]    MAX_MIN_LEN_C = CNT_W'(MAX_MIN_LEN);
  localparam logic [LETTER_W-1:0] STOP_RESET    = LETTER_W'(24);
  localparam logic [LETTER_W-1:0] MASK_RESET    = LETTER_W'(23);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LENGTH = 2'd0,
    REG_STOP_CODE  = 2'd1,
    REG_MASK_CODE  = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/sorm_ram.sv
// ----------------------------------------------------------------------------
// sorm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sorm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/short_orf_masker_core.sv
// ----------------------------------------------------------------------------
// short_orf_masker_core
// Masks segments between stop letters that are shorter than a minimum length.
// ----------------------------------------------------------------------------
// Usage:
//   Letters enter on the s_axis channel, one per transfer, with tlast on the
//   last letter of a sequence. Results leave on m_axis: the letter or the mask
//   code, tlast on the last result caused by an input letter, tuser on the
//   final result of a sequence, which also carries the kept length total.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
//   is to write it only while idle, the block itself does not enforce this.
// Sequencing:
//   A letter that is only held gives no result. Each held letter that is
//   flushed is read from the letter buffer RAM and then loaded into the
//   output register; a letter that passes through is loaded after them. The
//   single read port of the buffer RAM paces a burst. s_axis_tready is low
//   while a burst is in progress.
// Reset clears the sequencer state, the segment state and the output valid
// flag and loads the register defaults. When a valid result meets a low
// m_axis_tready the output register holds it and the sequencer waits to load the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module short_orf_masker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [sorm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sorm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input letters.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] letter, [7] zero
  input  wire logic        s_axis_tlast,   // seq_last
  // Results.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [6:0] out_letter, [30:7] kept_total, [31] zero
  output logic             m_axis_tlast,   // run_last
  output logic             m_axis_tuser    // seq_done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_TAIL
  } state_t;

  state_t state;

  // Configuration registers.
  logic [sorm_pkg::CNT_W-1:0]    min_length;
  logic [sorm_pkg::LETTER_W-1:0] stop_code;
  logic [sorm_pkg::LETTER_W-1:0] mask_code;

  // Segment state.
  logic [sorm_pkg::CNT_W-1:0]   segment_count;
  logic                         segment_committed;
  logic [sorm_pkg::TOTAL_W-1:0] kept_sum;

  // Burst sequencer.
  logic [sorm_pkg::CNT_W-1:0]    flush_n;
  logic [sorm_pkg::CNT_W-1:0]    idx;
  logic                          masked;
  logic                          have_tail;
  logic [sorm_pkg::LETTER_W-1:0] tail_letter;
  logic                          item_last;

  // Output register.
  logic                          out_valid;
  logic [sorm_pkg::LETTER_W-1:0] out_letter;
  logic                          run_last;
  logic                          seq_done;
  logic [sorm_pkg::TOTAL_W-1:0]  kept_total;

  logic [sorm_pkg::LETTER_W-1:0] rd_data;

  logic [sorm_pkg::LETTER_W-1:0] in_letter;
  logic                          accept;
  logic                          slot_free;
  logic                          out_load;
  logic                          is_stop;
  logic [sorm_pkg::CNT_W-1:0]    eff_min;
  logic [sorm_pkg::CNT_W-1:0]    new_cnt;
  logic                          hold_path;
  logic                          commit;
  logic [sorm_pkg::CNT_W-1:0]    add_n;
  logic [sorm_pkg::TOTAL_W:0]    kept_sum_wide;
  logic [sorm_pkg::TOTAL_W-1:0]  kept_sum_next;
  logic [sorm_pkg::CNT_W-1:0]    flush_n_next;
  logic                          masked_next;
  logic                          have_tail_next;
  logic [sorm_pkg::CNT_W-1:0]    idx_inc;
  logic                          flush_done;

  assign in_letter     = s_axis_tdata[sorm_pkg::LETTER_W-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;
  assign out_load      = slot_free && ((state == ST_EMIT) || (state == ST_TAIL));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, kept_total, out_letter};
  assign m_axis_tlast  = run_last;
  assign m_axis_tuser  = seq_done;

  assign idx_inc    = idx + 1'b1;
  assign flush_done = (idx_inc == flush_n);

  // Decision for an accepted letter, taken from the state before it.
  always_comb begin
    eff_min   = (min_length > sorm_pkg::MAX_MIN_LEN_C) ? sorm_pkg::MAX_MIN_LEN_C : min_length;
    is_stop   = (in_letter == stop_code);
    hold_path = !is_stop && !segment_committed;
    new_cnt   = segment_count + 1'b1;
    commit    = hold_path && (new_cnt >= eff_min);

    add_n = '0;
    if (commit) begin
      add_n = new_cnt;
    end else if (!is_stop && segment_committed) begin
      add_n = sorm_pkg::CNT_W'(1);
    end
    kept_sum_wide = {1'b0, kept_sum} + (sorm_pkg::TOTAL_W+1)'(add_n);
    kept_sum_next = kept_sum_wide[sorm_pkg::TOTAL_W] ? sorm_pkg::TOTAL_MAX
                                                     : kept_sum_wide[sorm_pkg::TOTAL_W-1:0];

    flush_n_next   = '0;
    masked_next    = 1'b0;
    have_tail_next = 1'b0;
    if (is_stop) begin
      flush_n_next   = segment_committed ? '0 : segment_count;
      masked_next    = (eff_min != '0);
      have_tail_next = 1'b1;
    end else if (segment_committed) begin
      have_tail_next = 1'b1;
    end else if (commit) begin
      flush_n_next = new_cnt;
    end else if (s_axis_tlast) begin
      flush_n_next = new_cnt;
      masked_next  = 1'b1;
    end
  end

  sorm_ram #(
    .WIDTH (sorm_pkg::LETTER_W),
    .DEPTH (sorm_pkg::MAX_MIN_LEN)
  ) u_buf (
    .clk     (clk),
    .wr_en   (accept && hold_path),
    .wr_addr (segment_count[sorm_pkg::ADDR_W-1:0]),
    .wr_data (in_letter),
    .rd_en   (state == ST_READ),
    .rd_addr (idx[sorm_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      min_length        <= '0;
      stop_code         <= sorm_pkg::STOP_RESET;
      mask_code         <= sorm_pkg::MASK_RESET;
      segment_count     <= '0;
      segment_committed <= 1'b0;
      kept_sum          <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sorm_pkg::REG_MIN_LENGTH: min_length <= cfg_wdata[sorm_pkg::CNT_W-1:0];
          sorm_pkg::REG_STOP_CODE:  stop_code  <= cfg_wdata;
          sorm_pkg::REG_MASK_CODE:  mask_code  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            flush_n     <= flush_n_next;
            masked      <= masked_next;
            have_tail   <= have_tail_next;
            tail_letter <= in_letter;
            item_last   <= s_axis_tlast;
            idx         <= '0;
            kept_sum    <= kept_sum_next;
            if (is_stop || commit || s_axis_tlast) begin
              segment_count <= '0;
            end else if (hold_path) begin
              segment_count <= new_cnt;
            end
            // The end of a sequence also ends its segment.
            segment_committed <= !s_axis_tlast &&
                                 (commit || (segment_committed && !is_stop));
            if (flush_n_next != '0) begin
              state <= ST_READ;
            end else if (have_tail_next) begin
              state <= ST_TAIL;
            end
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_letter <= masked ? mask_code : rd_data;
            run_last   <= flush_done && !have_tail;
            seq_done   <= flush_done && !have_tail && item_last;
            kept_total <= (flush_done && !have_tail && item_last) ? kept_sum : '0;
            idx        <= idx_inc;
            if (!flush_done) begin
              state <= ST_READ;
            end else if (have_tail) begin
              state <= ST_TAIL;
            end else begin
              state <= ST_IDLE;
              if (item_last) begin
                kept_sum <= '0;
              end
            end
          end
        end
        ST_TAIL: begin
          if (slot_free) begin
            out_letter <= tail_letter;
            run_last   <= 1'b1;
            seq_done   <= item_last;
            kept_total <= item_last ? kept_sum : '0;
            state      <= ST_IDLE;
            if (item_last) begin
              kept_sum <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/sorm_checker.sv
// ----------------------------------------------------------------------------
// sorm_checker
// Port-level checks of the short ORF masker, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // A stalled result keeps its payload.
  `SORM_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

  // The final result of a sequence is also the last result of its letter.
  `SORM_ASSERT(a_done_is_last, clk, rst, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "seq_done without run_last")

  // The kept total is zero on every result but the final one.
  `SORM_ASSERT(a_total_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[30:7] == 24'd0, "kept_total set before sequence end")

  // The last letter of a sequence always causes results, so the input stalls.
  `SORM_ASSERT(a_last_busy, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "input ready right after sequence end")

endmodule

bind short_orf_masker_core sorm_checker u_sorm_checker (.*);

`default_nettype wire
